FILE: rtl/core/windowed_moving_average_assert.svh
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication
`define WMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/wma_pkg.sv
package wma_pkg;

   localparam int WL_W     = 9;
   localparam int SAMPLE_W = 32;
   localparam int AVG_W    = 32;

   localparam logic [WL_W-1:0] WL_RESET = 9'd16;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/core/windowed_moving_average.sv
// Sequence: an add word passes through drop (only when the oldest sample must go), push,
// start, the serial divide and done; a clear word goes from start straight to done.
// The block takes no new word until the result of the last one is registered and it is
// back in idle; the serial divider takes the bulk of the time per add word.
// Reset (synchronous): empties the window, zeroes sum and pointer, window length back to 16.
// Sample ring contents are not cleared; an unread result holds the next word in flight.
`include "windowed_moving_average_assert.svh"

module windowed_moving_average import wma_pkg::*; #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [AVG_W-1:0]    rsp_average,
   output logic                       rsp_filled,
   input  logic                       csr_write_enable,
   input  logic [WL_W-1:0]            csr_write_data
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = SAMPLE_W + PTR_W;
   localparam int CMP_W = (CNT_W > WL_W) ? CNT_W : WL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_PUSH,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [WL_W-1:0]           len_ff, len_in;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SAMPLE_W-1:0]       sample_ff, sample_in;
   logic [AVG_W-1:0]          avg_ff, avg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]          rsp_average_ff, rsp_average_in;
   logic                      rsp_filled_ff, rsp_filled_in;

   logic [CMP_W-1:0]          len_ext;
   logic [CMP_W-1:0]          eff_ext;
   logic [CNT_W-1:0]          eff_len;
   logic [PTR_W:0]            wr_sum;
   logic [PTR_W-1:0]          wr_addr;
   logic [PTR_W-1:0]          ptr_next;
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [SAMPLE_W-1:0]       ram_rd_data;
   logic                      div_start;
   logic [AVG_W-1:0]          div_quotient;
   div_status_type            div_status;

   assign len_ext = CMP_W'(len_ff);
   assign eff_ext = (len_ff == '0) ? CMP_W'(1) :
                    (len_ext > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : len_ext;
   assign eff_len = CNT_W'(eff_ext);

   assign wr_sum  = {1'b0, ptr_ff} + (PTR_W + 1)'(count_ff);
   assign wr_addr = (wr_sum >= (PTR_W + 1)'(WINDOW_DEPTH)) ?
                    PTR_W'(wr_sum - (PTR_W + 1)'(WINDOW_DEPTH)) : PTR_W'(wr_sum);
   assign ptr_next = (ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_filled  = rsp_filled_ff;

   wma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   wma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      ptr_in         = ptr_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      sample_in      = sample_ff;
      avg_in         = avg_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      rsp_filled_in  = rsp_filled_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      div_start      = 1'b0;

      if (csr_write_enable) begin
         len_in = csr_write_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_CLEAR) begin
                  ptr_in   = '0;
                  count_in = '0;
                  sum_in   = '0;
                  state_in = ST_START;
               end else begin
                  sample_in = req_sample;
                  if (count_ff >= eff_len) begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_DROP;
                  end else begin
                     state_in = ST_PUSH;
                  end
               end
            end
         end
         ST_DROP: begin
            sum_in   = sum_ff - {{(SUM_W - SAMPLE_W){ram_rd_data[SAMPLE_W-1]}}, ram_rd_data};
            ptr_in   = ptr_next;
            count_in = count_ff - CNT_W'(1);
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            ram_wr_en = 1'b1;
            sum_in    = sum_ff + {{(SUM_W - SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
            count_in  = count_ff + CNT_W'(1);
            state_in  = ST_START;
         end
         ST_START: begin
            if (count_ff == '0) begin
               avg_in   = '0;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_status.done) begin
               avg_in   = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = avg_ff;
               rsp_filled_in  = (count_ff == eff_len);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= WL_RESET;
         ptr_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      avg_ff         <= avg_in;
      rsp_average_ff <= rsp_average_in;
      rsp_filled_ff  <= rsp_filled_in;
   end

   `WMA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "word accepted while previous one in flight")
   `WMA_ASSERT_NEXT(a_clear_empties, clock, reset, req_valid && req_ready && (req_func == FUNC_CLEAR), (count_ff == '0) && (sum_ff == '0), "clear did not empty window")
   `WMA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(WINDOW_DEPTH), "held count beyond ring depth")
   `WMA_ASSERT_SAME(a_div_in_wait, clock, reset, div_status.busy, state_ff == ST_WAIT, "divider busy outside wait state")

endmodule

FILE: rtl/core/wma_ram.sv
module wma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/wma_div.sv
module wma_div import wma_pkg::*; #(
   parameter int DIVIDEND_W = 40,
   parameter int DIVISOR_W  = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output logic [AVG_W-1:0]             quotient,
   output div_status_type               status
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [DIVIDEND_W-1:0] mag;
   logic [DIVIDEND_W-1:0] quo_signed;

   assign rem_shift  = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff       = rem_shift - {1'b0, den_ff};
   assign fits       = ~diff[DIVISOR_W];
   assign mag        = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
   assign quo_signed = neg_ff ? DIVIDEND_W'(-quo_ff) : quo_ff;
   assign quotient   = quo_signed[AVG_W-1:0];
   assign status     = '{busy: busy_ff, done: done_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         quo_in  = mag;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[DIVIDEND_W-1];
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

endmodule

FILE: tb/tb.sv
module tb;
   import wma_pkg::*;

   localparam int DEPTH = 256;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic [WL_W-1:0] WL_MAX = '1;

   typedef struct packed {
      logic signed [AVG_W-1:0] average;
      logic                    filled;
   } window_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_func;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [AVG_W-1:0]    rsp_average;
   logic                       rsp_filled;
   logic                       csr_write_enable;
   logic [WL_W-1:0]            csr_write_data;

   // window model
   logic signed [SAMPLE_W-1:0] held_samples [DEPTH];
   logic [7:0]                 oldest_idx;
   logic [WL_W-1:0]            held_cnt;
   logic signed [39:0]         window_sum;
   logic [WL_W-1:0]            window_len;

   window_result_type pending_averages[$];
   int                mismatches = 0;
   bit                no_idle = 1'b0;
   int                hold_request = 0;

   windowed_moving_average #(.WINDOW_DEPTH(DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_filled       (rsp_filled),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic window_result_type apply_word(input logic func,
                                                    input logic signed [SAMPLE_W-1:0] smp);
      window_result_type r;
      int                eff;
      logic [7:0]        wr;
      longint            q;
      eff = (window_len == 0) ? 1 : ((window_len > DEPTH) ? DEPTH : int'(window_len));
      if (func == FUNC_CLEAR) begin
         oldest_idx = '0;
         held_cnt   = '0;
         window_sum = '0;
      end else begin
         if (held_cnt >= eff && held_cnt > 0) begin
            window_sum = window_sum - held_samples[oldest_idx];
            oldest_idx = oldest_idx + 8'd1;
            held_cnt   = held_cnt - 1'b1;
         end
         wr = oldest_idx + held_cnt[7:0];
         held_samples[wr] = smp;
         held_cnt   = held_cnt + 1'b1;
         window_sum = window_sum + smp;
      end
      q = (held_cnt == 0) ? 0 : longint'(window_sum) / longint'(held_cnt);
      r.average = q[AVG_W-1:0];
      r.filled  = (held_cnt == eff);
      return r;
   endfunction

   // mostly short, a few long; always at least 1
   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return -1;
               default: return 0;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(0, 200)) - 100;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic func, input logic signed [SAMPLE_W-1:0] smp);
      int gap;
      gap = (no_idle || $urandom_range(0, 99) < 50) ? 0 : pick_stall();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      pending_averages.push_back(apply_word(func, smp));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_averages.size() != 0);
   endtask

   task automatic write_length(input logic [WL_W-1:0] len);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_len = len;
   endtask

   task automatic test_extremes();
      send_word(FUNC_CLEAR, $urandom);
      send_word(FUNC_ADD, SAMPLE_MAX);
      send_word(FUNC_ADD, SAMPLE_MAX);
      send_word(FUNC_ADD, SAMPLE_MIN);
      send_word(FUNC_ADD, SAMPLE_MIN);
      send_word(FUNC_ADD, -1);
   endtask

   task automatic test_zero_length();
      write_length('0);
      send_word(FUNC_ADD, 5);
      send_word(FUNC_ADD, -3);
      send_word(FUNC_ADD, SAMPLE_MIN);
   endtask

   task automatic test_length_lowered();
      write_length(9'd4);
      send_word(FUNC_CLEAR, '1);
      send_word(FUNC_ADD, 10);
      send_word(FUNC_ADD, -20);
      send_word(FUNC_ADD, 7);
      send_word(FUNC_ADD, 8);
      write_length(9'd2);
      send_word(FUNC_ADD, -9);
      send_word(FUNC_ADD, 100);
      send_word(FUNC_CLEAR, '0);
   endtask

   task automatic test_above_depth();
      write_length(WL_MAX);
      send_word(FUNC_CLEAR, $urandom);
      send_word(FUNC_ADD, -3);
      send_word(FUNC_ADD, -4);
   endtask

   task automatic run_phase(input logic [WL_W-1:0] len, input int words,
                            input int clear_permille, input bit start_clear);
      write_length(len);
      if (start_clear)
         send_word(FUNC_CLEAR, $urandom);
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 999) < clear_permille)
            send_word(FUNC_CLEAR, $urandom);
         else
            send_word(FUNC_ADD, rand_sample());
      end
   endtask

   task automatic test_random();
      run_phase(9'd1, 100, 30, 1'b0);
      run_phase(9'd256, 350, 2, 1'b1);
      run_phase(9'($urandom_range(2, 40)), 150, 20, 1'b0);
      run_phase(9'($urandom_range(257, 510)), 300, 2, 1'b1);
      run_phase(9'($urandom_range(0, 511)), 150, 10, 1'b0);
      no_idle = 1'b1;
      run_phase(WL_RESET, 150, 20, 1'b0);
      no_idle = 1'b0;
      run_phase(9'($urandom_range(1, 300)), 200, 10, 1'b0);
   endtask

   task automatic test_backpressure();
      drain();
      hold_request = 300;
      no_idle = 1'b1;
      repeat (6) send_word(FUNC_ADD, rand_sample());
      no_idle = 1'b0;
   endtask

   initial begin : receiver
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 99) < 30) begin
            n = pick_stall();
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      window_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_averages.size() == 0) begin
            $error("result word with none expected: average %0d filled %0b",
                   rsp_average, rsp_filled);
            mismatches++;
         end else begin
            want = pending_averages.pop_front();
            if (rsp_average !== want.average) begin
               $error("average: expected %0d, got %0d", want.average, rsp_average);
               mismatches++;
            end
            if (rsp_filled !== want.filled) begin
               $error("filled: expected %0b, got %0b", want.filled, rsp_filled);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #6000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_ADD;
      req_sample       = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      oldest_idx       = '0;
      held_cnt         = '0;
      window_sum       = '0;
      window_len       = WL_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_zero_length();
      test_length_lowered();
      test_above_depth();
      test_random();
      test_backpressure();

      drain();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_averages.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/wma_pkg.sv
rtl/core/wma_ram.sv
rtl/core/wma_div.sv
rtl/core/windowed_moving_average.sv
tb/tb.sv
